// ===== hw/rtl/tempo_step_time_map_assert.svh =====
// Assertion helpers for the step time map.
`ifndef TEMPO_STEP_TIME_MAP_ASSERT_SVH
`define TEMPO_STEP_TIME_MAP_ASSERT_SVH

// same-cycle implication
`define TSTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step time map check failed");

// next-cycle implication
`define TSTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step time map check failed");

`endif

// ===== hw/rtl/tstm_pkg.sv =====
package tstm_pkg;

  localparam int DUR_W   = 30;
  localparam int TIME_W  = 48;
  localparam int POS_W   = 32;
  localparam int TEMPO_W = 18;
  localparam int SPB_W   = 7;
  localparam int DEN_W   = TEMPO_W + SPB_W;
  localparam int NUM_W   = 64;
  localparam int CFG_W   = 18;

  localparam logic [37:0]        SIXTY_Q32 = 38'd257698037760;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN = 18'd256;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX = 18'd255744;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_S2T    = 3'd2;
  localparam logic [2:0] OP_T2S    = 3'd3;
  localparam logic [2:0] OP_DUR    = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [1:0] CFG_CONST_MODE = 2'd0;
  localparam logic [1:0] CFG_DEF_TEMPO  = 2'd1;
  localparam logic [1:0] CFG_SPB        = 2'd2;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [POS_W-1:0]   position;
    logic signed [TIME_W-1:0]  time_in;
    logic [TEMPO_W-1:0]        tempo_bpm;
  } item_t;

  typedef struct packed {
    logic signed [TIME_W-1:0]  time_out;
    logic signed [POS_W-1:0]   position_out;
    logic [1:0]                status;
  } result_t;

endpackage

// ===== hw/rtl/tempo_step_time_map.sv =====
// Clear, an unknown opcode and an append to a full table are answered straight from the idle state.
// An append runs the 64-step radix-2 divider for the step duration, then reads the last entry and writes the new one.
// Table: two entry reads; steps->seconds adds a multiply, seconds->steps a divide, after a search if needed.
// Fixed tempo (constant mode or empty table) first runs the 64-step divide for the step duration.
// One item at a time; busy is high until the result strobe; the receiver cannot stall.
// Reset clears the step count and loads config defaults; table contents are kept.
module tempo_step_time_map import tstm_pkg::*; #(
  parameter int MAX_STEPS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

`include "tempo_step_time_map_assert.svh"

  localparam int CW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int EW = CW + DUR_W;
  localparam int BW = NW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DSET, S_DIV, S_AP_RD, S_AP_WR, S_FB, S_FB_W, S_FA_W,
    S_RN, S_RN_W, S_BS, S_BS_W, S_CALC, S_MUL_W
  } state_e;

  state_e               state_q;
  logic [NW-1:0]        cnt_q;
  logic                 cmode_q;
  logic [TEMPO_W-1:0]   dtempo_q;
  logic [SPB_W-1:0]     spb_q;
  logic [2:0]           op_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [TIME_W-1:0] tin_q;
  logic [DEN_W-1:0]     den_q;
  logic [CW-1:0]        k_q;
  logic                 bh_q;
  logic [NW-1:0]        lo_q, hi_q;
  logic [EW-1:0]        b_q, r_q;
  logic [DUR_W-1:0]     span_q;
  logic [NW-1:0]        bidx_q;
  logic [NUM_W-1:0]     dn_q;
  logic [DUR_W-1:0]     rem_q, dvs_q;
  logic [5:0]           dcnt_q;
  logic                 dfin_q;
  logic [61:0]          prod_q;
  logic                 neg_q;
  result_t              res_q;
  logic                 valid_q;
  logic [EW-1:0]        rdata_q;
  logic [EW-1:0]        mem [MAX_STEPS];

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmode_q  <= 1'b0;
      dtempo_q <= 18'd30720;
      spb_q    <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONST_MODE: cmode_q  <= cfg_data_i[0];
        CFG_DEF_TEMPO:  dtempo_q <= cfg_data_i[TEMPO_W-1:0];
        CFG_SPB:        spb_q    <= cfg_data_i[SPB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SPB_W-1:0]   spb1;
  logic [TEMPO_W-1:0] tclamp, ftempo, tsel;
  logic [DEN_W-1:0]   den_in;
  logic [14:0]        i_in;
  logic               p_pos, i_ge_n, fix_in;
  logic [CW-1:0]      k_last, ra;
  logic [NW-1:0]      mid;
  logic [EW-1:0]      e_val, a_val;
  logic [DUR_W:0]     trial;
  logic               ge;
  logic [DUR_W-1:0]   rem_nx;
  logic [NUM_W-1:0]   dn_nx, negq;
  logic [64:0]        tsum;
  logic               t_sat;
  logic [POS_W-1:0]   t_pos;
  logic signed [34:0] dpos;
  logic [34:0]        dmag;
  logic [31:0]        m32;
  logic signed [48:0] tdiff;
  logic [47:0]        tmag;
  logic [45:0]        sval;
  logic [48:0]        ssum;
  logic               s_sat;
  logic [TIME_W-1:0]  s_time;

  always_comb begin
    spb1   = (spb_q == '0) ? SPB_W'(1) : spb_q;
    tclamp = item_i.tempo_bpm;
    if (item_i.tempo_bpm < TEMPO_MIN) tclamp = TEMPO_MIN;
    if (item_i.tempo_bpm > TEMPO_MAX) tclamp = TEMPO_MAX;
    ftempo = (dtempo_q < TEMPO_MIN) ? TEMPO_MIN : dtempo_q;
    tsel   = (item_i.opcode == OP_APPEND) ? tclamp : ftempo;
    den_in = DEN_W'(tsel) * DEN_W'(spb1);
    i_in   = item_i.position[30:16];
    p_pos  = !item_i.position[31] && (item_i.position != '0);
    i_ge_n = 32'(i_in) >= 32'(cnt_q);
    fix_in = cmode_q || (cnt_q == '0);
    k_last = CW'(cnt_q - NW'(1));
    mid    = lo_q + ((hi_q - lo_q) >> 1);

    unique case (state_q)
      S_FB:    ra = k_q;
      S_FB_W:  ra = k_q - CW'(1);
      S_AP_RD: ra = k_last;
      S_RN:    ra = k_last;
      S_BS:    ra = CW'(mid - NW'(1));
      default: ra = k_q;
    endcase

    e_val = ((cnt_q == '0) ? '0 : rdata_q) + EW'(dn_q[DUR_W-1:0]);
    a_val = (k_q == '0) ? '0 : rdata_q;

    trial  = {rem_q, dn_q[NUM_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_nx = ge ? DUR_W'(trial - {1'b0, dvs_q}) : trial[DUR_W-1:0];
    dn_nx  = {dn_q[NUM_W-2:0], ge};

    negq = NUM_W'(0) - dn_nx;
    tsum = {1'b0, dn_nx} + 65'({bidx_q, 16'b0});
    if (neg_q) begin
      t_sat = dn_nx > 64'h8000_0000;
      t_pos = t_sat ? 32'h8000_0000 : negq[31:0];
    end else begin
      t_sat = tsum > 65'h7FFF_FFFF;
      t_pos = t_sat ? 32'h7FFF_FFFF : tsum[31:0];
    end

    dpos = $signed({{3{pos_q[31]}}, pos_q}) - $signed(35'({bidx_q, 16'b0}));
    dmag = dpos[34] ? 35'(-dpos) : 35'(dpos);
    m32  = dmag[31:0];

    tdiff = $signed({tin_q[47], tin_q}) - $signed({1'b0, 48'(r_q)});
    tmag  = tdiff[48] ? 48'(-tdiff) : tdiff[47:0];

    sval = 46'((prod_q + 62'd32768) >> 16);
    ssum = 49'(r_q) + 49'(sval);
    if (neg_q) begin
      s_sat  = 1'b0;
      s_time = 48'd0 - 48'(sval);
    end else begin
      s_sat  = ssum[48:47] != 2'b00;
      s_time = s_sat ? 48'h7FFF_FFFF_FFFF : ssum[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_AP_WR) begin
      mem[CW'(cnt_q)] <= e_val;
    end
    rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      op_q    <= '0;
      pos_q   <= '0;
      tin_q   <= '0;
      den_q   <= '0;
      k_q     <= '0;
      bh_q    <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      b_q     <= '0;
      r_q     <= '0;
      span_q  <= '0;
      bidx_q  <= '0;
      dn_q    <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      dcnt_q  <= '0;
      dfin_q  <= 1'b0;
      prod_q  <= '0;
      neg_q   <= 1'b0;
      res_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q  <= item_i.opcode;
            pos_q <= item_i.position;
            tin_q <= item_i.time_in;
            den_q <= den_in;
            res_q <= '0;
            unique case (item_i.opcode)
              OP_CLEAR: begin
                cnt_q   <= '0;
                valid_q <= 1'b1;
              end
              OP_APPEND: begin
                if (cnt_q == NW'(MAX_STEPS)) begin
                  res_q.status <= STATUS_FULL;
                  valid_q      <= 1'b1;
                end else begin
                  state_q <= S_DSET;
                end
              end
              OP_S2T, OP_DUR: begin
                if (fix_in) begin
                  state_q <= S_DSET;
                end else begin
                  priority if (!p_pos) begin
                    k_q  <= '0;
                    bh_q <= 1'b0;
                  end else if (i_ge_n) begin
                    k_q  <= k_last;
                    bh_q <= item_i.opcode == OP_S2T;
                  end else begin
                    k_q  <= CW'(i_in);
                    bh_q <= 1'b0;
                  end
                  state_q <= S_FB;
                end
              end
              OP_T2S: begin
                priority if (fix_in) begin
                  state_q <= S_DSET;
                end else if (item_i.time_in[47] || item_i.time_in == '0) begin
                  k_q     <= '0;
                  bh_q    <= 1'b0;
                  state_q <= S_FB;
                end else begin
                  state_q <= S_RN;
                end
              end
              default: valid_q <= 1'b1;
            endcase
          end
        end
        S_DSET: begin
          dn_q    <= NUM_W'(SIXTY_Q32) + NUM_W'(den_q >> 1);
          dvs_q   <= DUR_W'(den_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          dfin_q  <= 1'b0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          dn_q   <= dn_nx;
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) begin
            priority if (dfin_q) begin
              res_q.position_out <= t_pos;
              res_q.status       <= t_sat ? STATUS_SAT : STATUS_OK;
              valid_q            <= 1'b1;
              state_q            <= S_IDLE;
            end else if (op_q == OP_APPEND) begin
              state_q <= S_AP_RD;
            end else begin
              span_q  <= dn_nx[DUR_W-1:0];
              r_q     <= '0;
              bidx_q  <= '0;
              state_q <= S_CALC;
            end
          end
        end
        S_AP_RD: state_q <= S_AP_WR;
        S_AP_WR: begin
          cnt_q          <= cnt_q + NW'(1);
          res_q.time_out <= TIME_W'(e_val);
          valid_q        <= 1'b1;
          state_q        <= S_IDLE;
        end
        S_RN: state_q <= S_RN_W;
        S_RN_W: begin
          if (TIME_W'(rdata_q) <= tin_q[47:0]) begin
            k_q     <= k_last;
            bh_q    <= 1'b1;
            state_q <= S_FB;
          end else begin
            lo_q    <= '0;
            hi_q    <= cnt_q;
            state_q <= S_BS;
          end
        end
        S_BS: begin
          if ((hi_q - lo_q) > NW'(1)) begin
            state_q <= S_BS_W;
          end else begin
            k_q     <= CW'(lo_q);
            bh_q    <= 1'b0;
            state_q <= S_FB;
          end
        end
        S_BS_W: begin
          if (TIME_W'(rdata_q) <= tin_q[47:0]) lo_q <= mid;
          else hi_q <= mid;
          state_q <= S_BS;
        end
        S_FB: state_q <= S_FB_W;
        S_FB_W: begin
          b_q     <= rdata_q;
          state_q <= S_FA_W;
        end
        S_FA_W: begin
          span_q  <= DUR_W'(b_q - a_val);
          r_q     <= bh_q ? b_q : a_val;
          bidx_q  <= NW'(k_q) + NW'(bh_q);
          state_q <= S_CALC;
        end
        S_CALC: begin
          unique case (op_q)
            OP_DUR: begin
              res_q.time_out <= TIME_W'(span_q);
              valid_q        <= 1'b1;
              state_q        <= S_IDLE;
            end
            OP_S2T: begin
              prod_q  <= m32 * span_q;
              neg_q   <= dpos[34];
              state_q <= S_MUL_W;
            end
            default: begin
              dn_q    <= {tmag, 16'b0} + NUM_W'(span_q >> 1);
              dvs_q   <= span_q;
              rem_q   <= '0;
              dcnt_q  <= '0;
              dfin_q  <= 1'b1;
              neg_q   <= tdiff[48];
              state_q <= S_DIV;
            end
          endcase
        end
        S_MUL_W: begin
          res_q.time_out <= s_time;
          res_q.status   <= s_sat ? STATUS_SAT : STATUS_OK;
          valid_q        <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  `TSTM_ASSERT_NOW(a_done_idle, res_valid_o, !busy)
  `TSTM_ASSERT_NEXT(a_clear, start && !busy && item_i.opcode == OP_CLEAR, res_valid_o && cnt_q == '0)
  `TSTM_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= NW'(MAX_STEPS))
  `TSTM_ASSERT_NOW(a_div_rem, state_q == S_DIV, rem_q < dvs_q)

endmodule
